// ----- rtl/core/fbsc_pkg.sv -----
package fbsc_pkg;

  localparam int MAX_BLOCK_BYTES = 4096;
  localparam int LenW = $clog2(MAX_BLOCK_BYTES + 1);
  localparam logic [31:0] CrcPoly = 32'h04C11DB7;
  localparam logic [31:0] LowMask = 32'h003fffff;
  localparam logic [31:0] Base0 = 32'h00000000;
  localparam logic [31:0] Base1 = 32'h04000000;
  localparam logic [31:0] Base2 = 32'hc0000000;
  localparam logic [31:0] CmdLoad = 32'h00000001;
  localparam logic [31:0] CmdLast = 32'h00000004;
  localparam logic [12:0] WarnReset = 13'h400;
  localparam int QDepth = 4;
  localparam int QAw = 2;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_LAST  = 2'd2,
    KIND_ERR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HDR_CRC = 3'd1,
    ST_BODY_CRC = 3'd2,
    ST_REGION  = 3'd3,
    ST_RAN_OUT = 3'd4,
    ST_SHORT   = 3'd5,
    ST_BAD_LEN = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_HALT   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [1:0]  region;
    logic [22:0] offset;
    logic [7:0]  write_byte;
    logic [31:0] block_address;
    logic [11:0] block_length;
    logic [31:0] region_low;
    logic [31:0] region_high;
    logic        odd_header;
    logic        last_of_run;
  } out_item_t;

  // Classified event passed from the front part to the back part.
  typedef struct packed {
    logic        wr;        // payload write
    logic        done;      // block done, bounds update
    logic        last;      // last block
    logic        err;       // error after any other result
    logic [2:0]  status;
    logic [1:0]  region;
    logic [22:0] offset;
    logic [7:0]  wbyte;
    logic [31:0] addr;
    logic [11:0] len;
    logic        odd;
  } ev_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      x = x[31] ? ((x << 1) ^ CrcPoly) : (x << 1);
    end
    return x;
  endfunction

endpackage

// ----- rtl/core/fbsc_front.sv -----
module fbsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  fbsc_pkg::in_item_t item,
  input  logic [12:0]       warn_length,
  output fbsc_pkg::ev_t     ev
);

  fbsc_pkg::phase_t phase_r, phase_nxt;
  logic [fbsc_pkg::LenW-1:0] cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] hw_r [4];
  logic [1:0]  reg_r, reg_nxt;

  logic [31:0] crc_b;
  logic [31:0] cmd, addr, dlen, len;
  logic [1:0]  reg_cls;
  logic [31:0] base;

  // Header fields and the region of the block address. The last header byte
  // belongs to the CRC word, so the stored words are complete when it arrives.
  always_comb begin
    cmd = hw_r[0];
    addr = hw_r[1];
    dlen = hw_r[2];
    len = dlen - 32'd4;
    base = addr & ~fbsc_pkg::LowMask;
    if (base == fbsc_pkg::Base0) reg_cls = 2'd0;
    else if (base == fbsc_pkg::Base1) reg_cls = 2'd1;
    else if (base == fbsc_pkg::Base2) reg_cls = 2'd2;
    else reg_cls = 2'd3;
  end

  assign crc_b = fbsc_pkg::crc_byte(crc_r, item.data_byte);

  // Classification of one byte into at most two results.
  always_comb begin
    ev = '0;
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    crc_nxt = crc_r;
    reg_nxt = reg_r;
    if (take) begin
      unique case (phase_r)
        fbsc_pkg::PH_HEADER: begin
          crc_nxt = crc_b;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r[3:0] != 4'd15) begin
            if (item.end_of_input) begin
              ev.err = 1'b1;
              ev.status = fbsc_pkg::ST_SHORT;
              phase_nxt = fbsc_pkg::PH_HALT;
            end
          end else begin
            cnt_nxt = '0;
            if (crc_b != 32'd0) begin
              ev.err = 1'b1;
              ev.status = fbsc_pkg::ST_HDR_CRC;
              phase_nxt = fbsc_pkg::PH_HALT;
            end else if (cmd == fbsc_pkg::CmdLast && dlen == 32'd0) begin
              ev.last = 1'b1;
              ev.addr = addr;
              phase_nxt = fbsc_pkg::PH_HALT;
            end else if (dlen < 32'd4 || dlen > 32'(fbsc_pkg::MAX_BLOCK_BYTES)) begin
              ev.err = 1'b1;
              ev.status = fbsc_pkg::ST_BAD_LEN;
              phase_nxt = fbsc_pkg::PH_HALT;
            end else begin
              reg_nxt = reg_cls;
              crc_nxt = '0;
              phase_nxt = fbsc_pkg::PH_BODY;
              if (item.end_of_input) begin
                ev.err = 1'b1;
                ev.status = fbsc_pkg::ST_SHORT;
                phase_nxt = fbsc_pkg::PH_HALT;
              end
            end
          end
        end
        fbsc_pkg::PH_BODY: begin
          crc_nxt = crc_b;
          cnt_nxt = cnt_r + 1'b1;
          ev.region = reg_r;
          ev.addr = addr;
          ev.len = len[11:0];
          if (32'(cnt_r) < len && reg_r != 2'd3) begin
            ev.wr = 1'b1;
            ev.offset = 23'((addr & fbsc_pkg::LowMask) + 32'(cnt_r));
            ev.wbyte = item.data_byte;
          end
          if (32'(cnt_r) + 32'd1 >= dlen) begin
            cnt_nxt = '0;
            if (crc_b != 32'd0) begin
              ev.err = 1'b1;
              ev.status = fbsc_pkg::ST_BODY_CRC;
              phase_nxt = fbsc_pkg::PH_HALT;
            end else if (reg_r == 2'd3) begin
              ev.err = 1'b1;
              ev.status = fbsc_pkg::ST_REGION;
              phase_nxt = fbsc_pkg::PH_HALT;
            end else begin
              ev.done = 1'b1;
              ev.offset = 23'(addr & fbsc_pkg::LowMask);
              ev.odd = (cmd != fbsc_pkg::CmdLoad) || (dlen > 32'(warn_length));
              crc_nxt = '0;
              phase_nxt = fbsc_pkg::PH_HEADER;
              if (item.end_of_input) begin
                ev.err = 1'b1;
                ev.status = fbsc_pkg::ST_RAN_OUT;
                phase_nxt = fbsc_pkg::PH_HALT;
              end
            end
          end else if (item.end_of_input) begin
            ev.err = 1'b1;
            ev.status = fbsc_pkg::ST_SHORT;
            phase_nxt = fbsc_pkg::PH_HALT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fbsc_pkg::PH_HEADER;
      cnt_r <= '0;
      crc_r <= '0;
      reg_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
      reg_r <= reg_nxt;
    end
  end

  // Header words, little-endian byte lanes.
  always_ff @(posedge clk) begin
    if (take && phase_r == fbsc_pkg::PH_HEADER) begin
      hw_r[cnt_r[3:2]][8*cnt_r[1:0] +: 8] <= item.data_byte;
    end
  end

endmodule

// ----- rtl/core/fbsc_queue.sv -----
module fbsc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fbsc_pkg::ev_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output fbsc_pkg::ev_t dout
);

  fbsc_pkg::ev_t mem_r [fbsc_pkg::QDepth];
  logic [fbsc_pkg::QAw-1:0] wp_r, rp_r;
  logic [fbsc_pkg::QAw:0]   cnt_r;

  assign full = (cnt_r == (fbsc_pkg::QAw+1)'(fbsc_pkg::QDepth));
  assign empty = (cnt_r == '0);
  assign dout = mem_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (fbsc_pkg::QAw+1)'(push) - (fbsc_pkg::QAw+1)'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

endmodule

// ----- rtl/core/fbsc_back.sv -----
module fbsc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  fbsc_pkg::ev_t      ev,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output fbsc_pkg::out_item_t out_item
);

  logic [31:0] lo_r [3];
  logic [31:0] hi_r [3];
  logic        sec_r;     // first result of a two-result event already sent
  fbsc_pkg::out_item_t cur;
  logic        two, first_err, fin;
  logic [31:0] end_a, lo_n, hi_n;
  logic [1:0]  r;

  assign r = (ev.region == 2'd3) ? 2'd0 : ev.region;
  assign two = ev.err && (ev.wr || ev.done);
  assign first_err = ev.err && !two;
  assign end_a = ev.addr + 32'(ev.len);
  assign hi_n = (end_a > hi_r[r]) ? end_a : hi_r[r];
  assign lo_n = (ev.addr < lo_r[r]) ? ev.addr : lo_r[r];

  // Result formatting.
  always_comb begin
    cur = '0;
    if (sec_r || first_err) begin
      cur.kind = fbsc_pkg::KIND_ERR;
      cur.status = ev.status;
      cur.last_of_run = 1'b1;
    end else if (ev.last) begin
      cur.kind = fbsc_pkg::KIND_LAST;
      cur.block_address = ev.addr;
      cur.last_of_run = 1'b1;
    end else begin
      cur.kind = ev.done ? fbsc_pkg::KIND_DONE : fbsc_pkg::KIND_WRITE;
      cur.region = ev.region;
      cur.offset = ev.offset;
      cur.block_address = ev.addr;
      cur.block_length = ev.len;
      if (ev.done) begin
        cur.region_low = lo_n;
        cur.region_high = hi_n;
        cur.odd_header = ev.odd;
      end else begin
        cur.write_byte = ev.wbyte;
      end
      cur.last_of_run = !two;
    end
  end

  assign out_empty = q_empty;
  assign out_item = cur;
  assign fin = out_pop && !q_empty;
  assign q_pop = fin && (sec_r || !two);

  // Sequencing and region bounds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= '1;
        hi_r[i] <= '0;
      end
    end else if (fin) begin
      sec_r <= two && !sec_r;
      if (ev.done && !sec_r) begin
        lo_r[r] <= lo_n;
        hi_r[r] <= hi_n;
      end
    end
  end

endmodule

// ----- rtl/core/firmware_block_stream_checker_top.sv -----
// Channel | Ports                          | Request
// input   | in_push, in_full, in_item      | image byte and end flag
// result  | out_pop, out_empty, out_item   | write, block done, last, error
// config  | cfg_valid, cfg_ready, cfg_data | warn_length
// Bytes are classified combinationally; one byte is accepted per cycle while the queue is not full.
// A byte giving two results holds its queue entry until both results are taken.
// A four-entry queue between classifier and formatter absorbs stalls.
// Reset is synchronous and clears phase, counters, CRC and bounds.
// Bytes after a halt are accepted and dropped.
module firmware_block_stream_checker_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  fbsc_pkg::in_item_t  in_item,
  input  logic                out_pop,
  output logic                out_empty,
  output fbsc_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [12:0]         cfg_data
);

  logic [12:0] warn_r;
  fbsc_pkg::ev_t ev_f, ev_q;
  logic take, q_push, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign take = in_push && !in_full;
  assign q_push = take && (ev_f.wr || ev_f.done || ev_f.last || ev_f.err);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) warn_r <= fbsc_pkg::WarnReset;
    else if (cfg_valid) warn_r <= cfg_data;
  end

  fbsc_front u_front (
    .clk, .rst_n, .take, .item(in_item), .warn_length(warn_r), .ev(ev_f)
  );

  fbsc_queue u_queue (
    .clk, .rst_n, .push(q_push), .din(ev_f), .full(in_full),
    .pop(q_pop), .empty(q_empty), .dout(ev_q)
  );

  fbsc_back u_back (
    .clk, .rst_n, .q_empty, .ev(ev_q), .q_pop, .out_empty,
    .out_pop, .out_item
  );

endmodule

// ----- rtl/core/fbsc_checker.sv -----
module fbsc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_pop,
  input logic                out_empty,
  input fbsc_pkg::out_item_t out_item
);

  // An error result always closes its run.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind == fbsc_pkg::KIND_ERR) |-> out_item.last_of_run)
    else $error("error result not last of run");

  // A write never carries region bounds.
  a_wr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind == fbsc_pkg::KIND_WRITE) |-> out_item.region_high == 0)
    else $error("write result carries bounds");

  // A waiting result holds while not taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("result changed while stalled");

  // Nothing to give right after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("not empty after reset");

endmodule

bind firmware_block_stream_checker_top fbsc_checker u_fbsc_checker (
  .clk, .rst_n, .in_full, .out_pop, .out_empty, .out_item
);
